[rtl/pcm_fifo_sound_port_top_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef PCM_FIFO_SOUND_PORT_TOP_MACROS_SVH
`define PCM_FIFO_SOUND_PORT_TOP_MACROS_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define PFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Asserts that an antecedent implies a consequent in the next cycle.
`define PFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/pfs_pkg.sv]
// Package with shared types and constants of the PCM FIFO sound port.
package pfs_pkg;
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [15:0] ADDR_FM_MASK  = 16'hA460;
    localparam logic [15:0] ADDR_ZERO_A   = 16'hA462;
    localparam logic [15:0] ADDR_ZERO_B   = 16'hA464;
    localparam logic [15:0] ADDR_STATUS   = 16'hA466;
    localparam logic [15:0] ADDR_FIFO_CTL = 16'hA468;
    localparam logic [15:0] ADDR_DAC_CTL  = 16'hA46A;
    localparam logic [15:0] ADDR_FIFO_DAT = 16'hA46C;
    localparam logic [15:0] ADDR_MUTE     = 16'hA66E;

    localparam logic [15:0] GAIN_RESET = 16'h8000;
    localparam logic [7:0]  DAC_RESET  = 8'h32;
    localparam logic [15:0] THR_RESET  = 16'h0080;
    localparam logic [15:0] THR_MAX    = 16'h7FFC;
    localparam logic [7:0]  MUTE_RESET = 8'h01;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } item_t;
endpackage

[rtl/pfs_queue.sv]
// Two-entry queue that decouples the front end from the back end.
module pfs_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  pfs_pkg::item_t in_item,
    output logic           in_full,
    output logic           out_valid,
    input  logic           out_take,
    output pfs_pkg::item_t out_item
);
    pfs_pkg::item_t mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_full   = cnt_reg == 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && !in_full;
    assign pop       = out_valid && out_take;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[rtl/pfs_engine.sv]
// Back end: register file, FIFO memory, sample event sequencer and result register.
module pfs_engine
#(
    parameter int FIFO_BYTES = 32768,
    parameter int BOARD_CODE = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  pfs_pkg::item_t     item,
    output logic               item_take,
    input  logic [15:0]        pcm_gain,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         read_data,
    output logic signed [15:0] sample_left,
    output logic signed [15:0] sample_right,
    output logic               irq_line
);
    localparam int AW = $clog2(FIFO_BYTES);
    localparam int FW = AW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_DATA = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SCL  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [7:0] mem_reg [FIFO_BYTES];
    logic [7:0] rdata_reg;

    logic [AW-1:0] head_reg, tail_reg;
    logic [FW-1:0] fill_reg;
    logic [7:0]  fctl_reg, dac_reg, mute_reg, vol_reg, fm_reg;
    logic [15:0] thr_reg;
    logic        irq_reg;
    logic signed [15:0] left_reg, right_reg;
    logic [2:0]  phase_reg;
    logic [2:0]  st_reg;
    logic        chan_reg;
    logic        second_reg;
    logic [7:0]  hi_reg;
    logic signed [15:0] raw_reg;
    logic signed [32:0] prod_reg;
    logic        todo_r_reg;

    logic        ov_reg;
    logic [7:0]  ov_rd_reg;
    logic signed [15:0] ov_l_reg, ov_r_reg;
    logic        ov_irq_reg;

    logic        ov_free;
    logic        do_write;
    logic        push;
    logic [7:0]  rd_val;
    logic [2:0]  need;
    logic        sample_hit;
    logic        start_seq;
    logic        audible;
    logic signed [32:0] quot;
    logic signed [15:0] sat;
    logic [AW-1:0] head_inc;

    assign ov_free   = !ov_reg || !out_stall;
    assign item_take = item_valid && st_reg == ST_IDLE && ov_free;
    assign do_write  = item_take && item.kind == pfs_pkg::KIND_WRITE;
    assign push      = do_write && item.addr == pfs_pkg::ADDR_FIFO_DAT
                       && fill_reg < FW'(FIFO_BYTES);
    assign head_inc  = (32'(head_reg) + 32'd1 >= 32'(FIFO_BYTES)) ? '0 : head_reg + 1'b1;
    assign need      = dac_reg[6] ? 3'(dac_reg[5]) + 3'(dac_reg[4])
                                  : (3'(dac_reg[5]) + 3'(dac_reg[4])) << 1;
    assign sample_hit = phase_reg == 3'd7 && fctl_reg[7] && FW'(need) <= fill_reg;
    assign start_seq = item_take && item.kind == pfs_pkg::KIND_TICK && sample_hit
                       && !fctl_reg[6] && (dac_reg[5] || dac_reg[4]);
    assign audible   = fctl_reg[7] && !fctl_reg[6] && !mute_reg[0];
    assign quot      = (prod_reg < 0) ? -((-prod_reg) >>> 15) : (prod_reg >>> 15);
    assign sat       = (quot > 33'sd32767) ? 16'sh7FFF :
                       (quot < -33'sd32768) ? 16'sh8000 : quot[15:0];

    always_comb
    begin
        unique case (item.addr)
            pfs_pkg::ADDR_FM_MASK:  rd_val = {4'(BOARD_CODE), 2'b00, fm_reg[1:0]};
            pfs_pkg::ADDR_ZERO_A,
            pfs_pkg::ADDR_ZERO_B,
            pfs_pkg::ADDR_FIFO_DAT: rd_val = 8'h00;
            pfs_pkg::ADDR_STATUS:   rd_val = {fill_reg >= FW'(FIFO_BYTES), fill_reg == '0,
                                              5'b00000, phase_reg[2]};
            pfs_pkg::ADDR_FIFO_CTL: rd_val = {fctl_reg[7:5], irq_reg, fctl_reg[3:0]};
            pfs_pkg::ADDR_DAC_CTL:  rd_val = dac_reg;
            pfs_pkg::ADDR_MUTE:     rd_val = mute_reg;
            default:                rd_val = 8'hFF;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= item.data;
        end
        rdata_reg <= mem_reg[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0; tail_reg <= '0; fill_reg <= '0;
            fctl_reg <= '0; dac_reg <= pfs_pkg::DAC_RESET; thr_reg <= pfs_pkg::THR_RESET;
            mute_reg <= pfs_pkg::MUTE_RESET; vol_reg <= '0; fm_reg <= '0;
            irq_reg <= 1'b0; left_reg <= '0; right_reg <= '0; phase_reg <= '0;
            st_reg <= ST_IDLE; chan_reg <= 1'b0; second_reg <= 1'b0; hi_reg <= '0;
            raw_reg <= '0; prod_reg <= '0; todo_r_reg <= 1'b0;
            ov_reg <= 1'b0; ov_rd_reg <= '0; ov_l_reg <= '0; ov_r_reg <= '0;
            ov_irq_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            if (item_take)
            begin
                ov_rd_reg <= (item.kind == pfs_pkg::KIND_READ) ? rd_val : 8'h00;
                st_reg <= start_seq ? ST_RD : ST_DONE;
                if (do_write)
                begin
                    unique case (item.addr)
                        pfs_pkg::ADDR_FM_MASK: fm_reg <= item.data;
                        pfs_pkg::ADDR_STATUS:  vol_reg <= item.data;
                        pfs_pkg::ADDR_MUTE:    mute_reg <= item.data;
                        pfs_pkg::ADDR_FIFO_DAT:
                        begin
                            if (push)
                            begin
                                tail_reg <= (32'(tail_reg) + 32'd1 >= 32'(FIFO_BYTES))
                                            ? '0 : tail_reg + 1'b1;
                                fill_reg <= fill_reg + 1'b1;
                            end
                        end
                        pfs_pkg::ADDR_DAC_CTL:
                        begin
                            if (fctl_reg[5])
                            begin
                                thr_reg <= (item.data == 8'hFF) ? pfs_pkg::THR_MAX
                                           : ({8'h00, item.data} + 16'd1) << 7;
                            end
                            else
                            begin
                                dac_reg <= item.data;
                            end
                        end
                        pfs_pkg::ADDR_FIFO_CTL:
                        begin
                            if ((fctl_reg & 8'h87) != (item.data & 8'h87))
                            begin
                                phase_reg <= '0;
                                if (!item.data[7])
                                begin
                                    left_reg <= '0; right_reg <= '0;
                                end
                            end
                            if (!item.data[4])
                            begin
                                irq_reg <= 1'b0;
                            end
                            if (fctl_reg[3] != item.data[3])
                            begin
                                head_reg <= '0; tail_reg <= '0; fill_reg <= '0;
                            end
                            fctl_reg <= item.data;
                        end
                        default: ;
                    endcase
                end
                else if (item.kind == pfs_pkg::KIND_TICK)
                begin
                    phase_reg <= phase_reg + 3'd1;
                    if (sample_hit)
                    begin
                        left_reg <= '0; right_reg <= '0;
                        if (start_seq)
                        begin
                            chan_reg   <= !dac_reg[5];
                            todo_r_reg <= dac_reg[5] && dac_reg[4];
                            second_reg <= 1'b0;
                        end
                        else if (32'(fill_reg) == 32'(thr_reg))
                        begin
                            irq_reg <= 1'b1;
                        end
                    end
                end
            end
            else
            begin
                unique case (st_reg)
                    ST_IDLE: ;
                    ST_RD:
                    begin
                        head_reg <= head_inc;
                        fill_reg <= fill_reg - 1'b1;
                        st_reg   <= ST_DATA;
                    end
                    ST_DATA:
                    begin
                        if (dac_reg[6])
                        begin
                            raw_reg <= {rdata_reg, 8'h00};
                            st_reg  <= ST_MUL;
                        end
                        else if (!second_reg)
                        begin
                            hi_reg     <= rdata_reg;
                            second_reg <= 1'b1;
                            st_reg     <= ST_RD;
                        end
                        else
                        begin
                            raw_reg <= {hi_reg, rdata_reg};
                            st_reg  <= ST_MUL;
                        end
                    end
                    ST_MUL:
                    begin
                        prod_reg <= $signed({1'b0, pcm_gain}) * raw_reg;
                        st_reg   <= ST_SCL;
                    end
                    ST_SCL:
                    begin
                        if (!chan_reg)
                        begin
                            left_reg <= sat;
                        end
                        else
                        begin
                            right_reg <= sat;
                        end
                        if (!chan_reg && todo_r_reg)
                        begin
                            chan_reg   <= 1'b1;
                            second_reg <= 1'b0;
                            st_reg     <= ST_RD;
                        end
                        else
                        begin
                            if (32'(fill_reg) == 32'(thr_reg))
                            begin
                                irq_reg <= 1'b1;
                            end
                            st_reg <= ST_DONE;
                        end
                    end
                    ST_DONE:
                    begin
                        ov_reg     <= 1'b1;
                        ov_l_reg   <= audible ? left_reg : '0;
                        ov_r_reg   <= audible ? right_reg : '0;
                        ov_irq_reg <= irq_reg && fctl_reg[5];
                        st_reg     <= ST_IDLE;
                    end
                    default: st_reg <= ST_IDLE;
                endcase
            end
        end
    end

    assign out_valid    = ov_reg;
    assign read_data    = ov_rd_reg;
    assign sample_left  = ov_l_reg;
    assign sample_right = ov_r_reg;
    assign irq_line     = ov_irq_reg;
endmodule

[rtl/pcm_fifo_sound_port_top.sv]
// PCM FIFO sound port: a bus access or a tick without a sample event passes from the input
// queue through the engine state register to the result register; the engine takes a new
// transaction only when it is idle and its result register is free. A sample event adds
// a FIFO memory read, multiply and scale step for each sample, two reads for a 16-bit one.
// One transaction is worked at a time; two more wait in the input queue.
// The FIFO memory needs no clearing pass; reset clears all control state at once.
module pcm_fifo_sound_port_top
#(
    parameter int FIFO_BYTES = 32768,
    parameter int BOARD_CODE = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [15:0]        bus_addr,
    input  logic [7:0]         bus_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         read_data,
    output logic signed [15:0] sample_left,
    output logic signed [15:0] sample_right,
    output logic               irq_line
);
    logic [15:0]    gain_reg;
    pfs_pkg::item_t in_item;
    pfs_pkg::item_t q_item;
    logic           q_full;
    logic           q_valid;
    logic           q_take;

    assign pready   = 1'b1;
    assign prdata   = (paddr == 2'd0) ? {16'h0000, gain_reg} : 32'h0000_0000;
    assign in_stall = q_full;
    assign in_item  = '{kind: kind, addr: bus_addr, data: bus_data};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= pfs_pkg::GAIN_RESET;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            gain_reg <= pwdata[15:0];
        end
    end

    pfs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_full   (q_full),
        .out_valid (q_valid),
        .out_take  (q_take),
        .out_item  (q_item)
    );

    pfs_engine #(.FIFO_BYTES(FIFO_BYTES), .BOARD_CODE(BOARD_CODE)) u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (q_valid),
        .item         (q_item),
        .item_take    (q_take),
        .pcm_gain     (gain_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .irq_line     (irq_line)
    );
endmodule

[rtl/pfs_checker.sv]
// Port-level checker for the PCM FIFO sound port, bound to the top level.
`include "pcm_fifo_sound_port_top_macros.svh"
module pfs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  read_data,
    input logic [15:0] sample_left
);
    `PFS_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready, "pready low")
    `PFS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_data), "result dropped")
    `PFS_ASSERT_NEXT(a_hold_left, clk, rst_n, out_valid && out_stall, $stable(sample_left), "left sample changed")
    `PFS_ASSERT_NEXT(a_gap, clk, rst_n, out_valid && !out_stall, !out_valid, "back to back result")
endmodule

bind pcm_fifo_sound_port_top pfs_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .sample_left (sample_left)
);

[bench/pcm_fifo_sound_port_checker.sv]
// Checker that predicts and compares the results of the PCM FIFO sound port.
`timescale 1ns / 1ps
module pcm_fifo_sound_port_checker
    import pfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               gain_we,
    input  logic [15:0]        gain_value,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [15:0]        bus_addr,
    input  logic [7:0]         bus_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         read_data,
    input  logic signed [15:0] sample_left,
    input  logic signed [15:0] sample_right,
    input  logic               irq_line,
    output int                 fail_count,
    output int                 pending_count
);
    localparam int DEPTH = 32768;
    localparam int BOARD = 4;

    typedef struct packed {
        logic [7:0]  rd;
        logic [15:0] left;
        logic [15:0] right;
        logic        irq;
    } port_result_t;

    port_result_t expected_q[$];
    logic [7:0]  fifo_mem [DEPTH];
    int          head, tail, fill;
    logic [7:0]  fifo_ctl, dac_ctl, mute_ctl, vol_ctl, fm_msk;
    int          threshold;
    logic        irq_flag;
    int          hold_l, hold_r;
    logic [2:0]  phase;
    int          gain;

    assign pending_count = expected_q.size();

    function automatic logic [7:0] pop_byte();
        logic [7:0] b;
        if (fill == 0)
            return 8'h00;
        b = fifo_mem[head];
        head = (head + 1 >= DEPTH) ? 0 : head + 1;
        fill--;
        return b;
    endfunction

    function automatic int pop_sample();
        int raw;
        longint v;
        logic [7:0] hi;
        logic [7:0] lo;
        if (dac_ctl[6]) begin
            raw = $signed(pop_byte()) * 256;
        end
        else begin
            hi = pop_byte();
            lo = pop_byte();
            raw = $signed({hi, lo});
        end
        v = (longint'(gain) * raw) / 32768;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return int'(v);
    endfunction

    function automatic void play_sample();
        int per, need;
        per = dac_ctl[6] ? 1 : 2;
        need = (int'(dac_ctl[5]) + int'(dac_ctl[4])) * per;
        if (fill < need)
            return;
        hold_l = 0;
        hold_r = 0;
        if (!fifo_ctl[6]) begin
            if (dac_ctl[5])
                hold_l = pop_sample();
            if (dac_ctl[4])
                hold_r = pop_sample();
        end
        if (fill == threshold)
            irq_flag = 1'b1;
    endfunction

    function automatic void bus_store(logic [15:0] a, logic [7:0] d);
        case (a)
            ADDR_FM_MASK: fm_msk = d;
            ADDR_STATUS:  vol_ctl = d;
            ADDR_FIFO_CTL:
            begin
                if ((fifo_ctl & 8'h87) != (d & 8'h87)) begin
                    phase = 3'd0;
                    if (!d[7]) begin
                        hold_l = 0;
                        hold_r = 0;
                    end
                end
                if (!d[4])
                    irq_flag = 1'b0;
                if (fifo_ctl[3] != d[3]) begin
                    head = 0;
                    tail = 0;
                    fill = 0;
                end
                fifo_ctl = d;
            end
            ADDR_DAC_CTL:
            begin
                if (fifo_ctl[5])
                    threshold = (d == 8'hFF) ? int'(THR_MAX) : (int'(d) + 1) * 128;
                else
                    dac_ctl = d;
            end
            ADDR_FIFO_DAT:
            begin
                if (fill < DEPTH) begin
                    fifo_mem[tail] = d;
                    tail = (tail + 1 >= DEPTH) ? 0 : tail + 1;
                    fill++;
                end
            end
            ADDR_MUTE: mute_ctl = d;
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] bus_fetch(logic [15:0] a);
        case (a)
            ADDR_FM_MASK: return {4'(BOARD), 2'b00, fm_msk[1:0]};
            ADDR_ZERO_A, ADDR_ZERO_B, ADDR_FIFO_DAT: return 8'h00;
            ADDR_STATUS: return {fill >= DEPTH, fill == 0, 5'b0, phase >= 3'd4};
            ADDR_FIFO_CTL: return {fifo_ctl[7:5], irq_flag, fifo_ctl[3:0]};
            ADDR_DAC_CTL: return dac_ctl;
            ADDR_MUTE: return mute_ctl;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic port_result_t predict_port(logic [1:0] k, logic [15:0] a,
                                                  logic [7:0] d);
        port_result_t r;
        logic audible;
        r.rd = 8'h00;
        if (k == KIND_WRITE) begin
            bus_store(a, d);
        end
        else if (k == KIND_READ) begin
            r.rd = bus_fetch(a);
        end
        else if (k == KIND_TICK) begin
            phase = phase + 3'd1;
            if (phase == 3'd0 && fifo_ctl[7])
                play_sample();
        end
        audible = fifo_ctl[7] && !fifo_ctl[6] && !mute_ctl[0];
        r.left = audible ? hold_l[15:0] : 16'h0;
        r.right = audible ? hold_r[15:0] : 16'h0;
        r.irq = irq_flag && fifo_ctl[5];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        port_result_t exp_r;
        if (!rst_n) begin
            expected_q.delete();
            fail_count <= 0;
            head = 0;
            tail = 0;
            fill = 0;
            fifo_ctl = 8'h00;
            dac_ctl = DAC_RESET;
            threshold = int'(THR_RESET);
            mute_ctl = MUTE_RESET;
            vol_ctl = 8'h00;
            fm_msk = 8'h00;
            irq_flag = 1'b0;
            hold_l = 0;
            hold_r = 0;
            phase = 3'd0;
            gain = int'(GAIN_RESET);
        end
        else begin
            if (gain_we)
                gain = int'(gain_value);
            if (in_valid && !in_stall)
                expected_q.push_back(predict_port(kind, bus_addr, bus_data));
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected transaction: rd=%h l=%h r=%h irq=%b",
                                 read_data, sample_left, sample_right, irq_line);
                    fail_count <= fail_count + 1;
                end
                else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.rd !== read_data || exp_r.left !== sample_left
                        || exp_r.right !== sample_right || exp_r.irq !== irq_line) begin
                        if (fail_count < 10)
                            $display("Mismatch: expected rd=%h l=%h r=%h irq=%b, %s%h l=%h r=%h irq=%b",
                                     exp_r.rd, exp_r.left, exp_r.right, exp_r.irq,
                                     "got rd=", read_data, sample_left, sample_right,
                                     irq_line);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[bench/pcm_fifo_sound_port_top_tb.sv]
// Testbench top that drives the PCM FIFO sound port and reports the verdict.
`timescale 1ns / 1ps
module pcm_fifo_sound_port_top_tb;
    import pfs_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic [15:0]        bus_addr;
    logic [7:0]         bus_data;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         read_data;
    logic signed [15:0] sample_left, sample_right;
    logic               irq_line;
    int                 fail_count, pending_count;
    int                 send_idle, recv_stall;
    bit                 hold_off;
    int                 quiet;
    bit                 gain_we;

    pcm_fifo_sound_port_top DUT (.*);

    assign gain_we = psel && penable && pwrite && pready && paddr == 2'd0;

    pcm_fifo_sound_port_checker checker_i (
        .clk, .rst_n, .gain_we, .gain_value(pwdata[15:0]),
        .in_valid, .in_stall, .kind, .bus_addr, .bus_data,
        .out_valid, .out_stall, .read_data, .sample_left, .sample_right, .irq_line,
        .fail_count, .pending_count
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_gain(logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(logic [1:0] k, logic [15:0] a, logic [7:0] d);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        bus_addr <= a;
        bus_data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_items(int count);
        int pick;
        logic [15:0] a;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_item(KIND_WRITE, ADDR_FIFO_DAT, 8'($urandom));
            end
            else if (pick < 65) begin
                send_item(KIND_TICK, 16'($urandom), 8'($urandom));
            end
            else if (pick < 80) begin
                a = 16'hA460 + 16'(2 * $urandom_range(7));
                if ($urandom_range(7) == 0)
                    a = ADDR_MUTE;
                send_item(KIND_READ, a, 8'($urandom));
            end
            else if (pick < 94) begin
                case ($urandom_range(4))
                    0: a = ADDR_FIFO_CTL;
                    1: a = ADDR_DAC_CTL;
                    2: a = ADDR_MUTE;
                    3: a = ADDR_FM_MASK;
                    default: a = ADDR_STATUS;
                endcase
                if (a == ADDR_FIFO_CTL)
                    send_item(KIND_WRITE, a, {1'b1, 1'($urandom_range(7) == 0),
                                              6'($urandom)});
                else if (a == ADDR_MUTE)
                    send_item(KIND_WRITE, a, {7'($urandom), 1'($urandom_range(3) == 0)});
                else
                    send_item(KIND_WRITE, a, 8'($urandom));
            end
            else begin
                send_item(2'($urandom), 16'($urandom), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 2'd0;
        pwdata = 32'h0;
        in_valid = 1'b0;
        kind = KIND_WRITE;
        bus_addr = 16'h0;
        bus_data = 8'h0;
        out_stall = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 1'b0;
        quiet = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_item(KIND_READ, ADDR_FM_MASK, 8'h00);
        send_item(KIND_READ, ADDR_STATUS, 8'h00);
        send_item(KIND_READ, ADDR_ZERO_A, 8'h00);
        send_item(KIND_READ, ADDR_ZERO_B, 8'h00);
        send_item(KIND_READ, 16'hFFFF, 8'h00);
        send_item(KIND_READ, 16'h0188, 8'h00);
        send_item(KIND_WRITE, 16'h0000, 8'hFF);
        send_item(KIND_WRITE, ADDR_FM_MASK, 8'hFF);
        send_item(KIND_WRITE, ADDR_MUTE, 8'h00);
        send_item(KIND_WRITE, ADDR_DAC_CTL, 8'h70);
        send_item(KIND_WRITE, ADDR_FIFO_CTL, 8'hB0);
        send_item(KIND_WRITE, ADDR_DAC_CTL, 8'hFF);
        send_item(KIND_WRITE, ADDR_DAC_CTL, 8'h00);
        send_item(KIND_WRITE, ADDR_FIFO_DAT, 8'h80);
        send_item(KIND_WRITE, ADDR_FIFO_DAT, 8'h7F);
        for (int i = 0; i < 8; i++)
            send_item(KIND_TICK, 16'h0, 8'h0);
        send_item(KIND_READ, ADDR_FIFO_CTL, 8'h00);
        send_item(2'd3, 16'hFFFF, 8'hFF);
        send_item(KIND_WRITE, ADDR_FIFO_CTL, 8'h08);
        drain_all();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_gain(16'h8000);
                1: write_gain(16'hFFFF);
                2: write_gain(16'h0000);
                default: write_gain(16'($urandom_range(65535)));
            endcase
            send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 72 : 25) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 72 : 25) : 0;
            send_item(KIND_WRITE, ADDR_FIFO_CTL, {8'hB0 | 8'($urandom_range(7))});
            send_item(KIND_WRITE, ADDR_DAC_CTL, 8'(8'h10 * $urandom_range(1, 7)));
            send_item(KIND_WRITE, ADDR_MUTE, 8'h00);
            if (ph == 0) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    random_items(30);
                join
            end
            random_items(100);
            drain_all();
        end
        write_gain(16'h4000);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
